// ----- sv/tf256_pkg.sv -----
// Shared types, constants and helpers for the Threefish-256 block cipher.
// Holds the microcode ROM, rotation tables and small modular-index helpers.
// No dependencies.
package tf256_pkg;

  localparam logic [63:0] TF_PARITY = 64'h1BD11BDAA9FC1A22;
  localparam logic [4:0] DEFAULT_GROUPS = 5'd9;

  // Configuration register indexes (byte address = 8 * index).
  typedef enum logic [2:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_TWEAK0 = 3'd4,
    REG_TWEAK1 = 3'd5,
    REG_ROUNDS = 3'd6
  } reg_idx_t;

  // Datapath operations selected by one control word.
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_WAIT,
    OP_INJ_ADD,
    OP_INJ_SUB,
    OP_ENC,
    OP_DEC,
    OP_DONE
  } uc_op_t;

  // Sequencer jump conditions.
  typedef enum logic [2:0] {
    JC_NONE,
    JC_ALWAYS,
    JC_NOT_START,
    JC_FUNC,
    JC_NOT_LAST,
    JC_ZERO
  } uc_jc_t;

  typedef logic [3:0] upc_t;

  typedef struct packed {
    uc_op_t     op;
    logic [1:0] rnd;
    uc_jc_t     jc;
    upc_t       target;
  } uc_word_t;

  // Subkey counter state handed to the key schedule.
  typedef struct packed {
    logic [5:0] s;
    logic [2:0] s5;
    logic [1:0] s3;
  } ks_ctrl_t;

  // Program addresses.
  localparam upc_t UPC_IDLE     = 4'd0;
  localparam upc_t UPC_WAIT     = 4'd1;
  localparam upc_t UPC_ENC_INJ0 = 4'd2;
  localparam upc_t UPC_ENC_R0   = 4'd3;
  localparam upc_t UPC_ENC_R1   = 4'd4;
  localparam upc_t UPC_ENC_R2   = 4'd5;
  localparam upc_t UPC_ENC_R3   = 4'd6;
  localparam upc_t UPC_ENC_INJ  = 4'd7;
  localparam upc_t UPC_DONE     = 4'd8;
  localparam upc_t UPC_DEC_INJ  = 4'd9;
  localparam upc_t UPC_DEC_R3   = 4'd10;
  localparam upc_t UPC_DEC_R2   = 4'd11;
  localparam upc_t UPC_DEC_R1   = 4'd12;
  localparam upc_t UPC_DEC_R0   = 4'd13;

  // Rotation constants, indexed by {group parity, round within group}.
  localparam logic [5:0] ROT_A [8] = '{6'd14, 6'd52, 6'd23, 6'd5,
                                       6'd25, 6'd46, 6'd58, 6'd32};
  localparam logic [5:0] ROT_B [8] = '{6'd16, 6'd57, 6'd40, 6'd37,
                                       6'd33, 6'd12, 6'd22, 6'd32};

  function automatic uc_word_t uc_rom(input upc_t a);
    uc_word_t w;
    w = '{op: OP_IDLE, rnd: 2'd0, jc: JC_ALWAYS, target: UPC_IDLE};
    case (a)
      UPC_IDLE:     w = '{op: OP_IDLE,    rnd: 2'd0, jc: JC_NOT_START, target: UPC_IDLE};
      UPC_WAIT:     w = '{op: OP_WAIT,    rnd: 2'd0, jc: JC_FUNC,      target: UPC_DEC_INJ};
      UPC_ENC_INJ0: w = '{op: OP_INJ_ADD, rnd: 2'd0, jc: JC_NONE,      target: UPC_IDLE};
      UPC_ENC_R0:   w = '{op: OP_ENC,     rnd: 2'd0, jc: JC_NONE,      target: UPC_IDLE};
      UPC_ENC_R1:   w = '{op: OP_ENC,     rnd: 2'd1, jc: JC_NONE,      target: UPC_IDLE};
      UPC_ENC_R2:   w = '{op: OP_ENC,     rnd: 2'd2, jc: JC_NONE,      target: UPC_IDLE};
      UPC_ENC_R3:   w = '{op: OP_ENC,     rnd: 2'd3, jc: JC_NONE,      target: UPC_IDLE};
      UPC_ENC_INJ:  w = '{op: OP_INJ_ADD, rnd: 2'd0, jc: JC_NOT_LAST,  target: UPC_ENC_R0};
      UPC_DONE:     w = '{op: OP_DONE,    rnd: 2'd0, jc: JC_ALWAYS,    target: UPC_IDLE};
      UPC_DEC_INJ:  w = '{op: OP_INJ_SUB, rnd: 2'd0, jc: JC_ZERO,      target: UPC_DONE};
      UPC_DEC_R3:   w = '{op: OP_DEC,     rnd: 2'd3, jc: JC_NONE,      target: UPC_IDLE};
      UPC_DEC_R2:   w = '{op: OP_DEC,     rnd: 2'd2, jc: JC_NONE,      target: UPC_IDLE};
      UPC_DEC_R1:   w = '{op: OP_DEC,     rnd: 2'd1, jc: JC_NONE,      target: UPC_IDLE};
      UPC_DEC_R0:   w = '{op: OP_DEC,     rnd: 2'd0, jc: JC_ALWAYS,    target: UPC_DEC_INJ};
      default:      w = '{op: OP_IDLE,    rnd: 2'd0, jc: JC_ALWAYS,    target: UPC_IDLE};
    endcase
    return w;
  endfunction

  // Residue of a 6-bit value, by constant compare-and-subtract steps.
  function automatic logic [2:0] mod5_6b(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (r >= 6'd40) r = r - 6'd40;
    if (r >= 6'd20) r = r - 6'd20;
    if (r >= 6'd10) r = r - 6'd10;
    if (r >= 6'd5)  r = r - 6'd5;
    return r[2:0];
  endfunction

  function automatic logic [1:0] mod3_6b(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (r >= 6'd48) r = r - 6'd48;
    if (r >= 6'd24) r = r - 6'd24;
    if (r >= 6'd12) r = r - 6'd12;
    if (r >= 6'd6)  r = r - 6'd6;
    if (r >= 6'd3)  r = r - 6'd3;
    return r[1:0];
  endfunction

  // a in 0..4, n in 0..3
  function automatic logic [2:0] add_mod5(input logic [2:0] a, input logic [1:0] n);
    logic [2:0] r;
    r = a + {1'b0, n};
    if (r >= 3'd5) r = r - 3'd5;
    return r;
  endfunction

  function automatic logic [1:0] inc_mod3(input logic [1:0] a);
    return (a == 2'd2) ? 2'd0 : a + 2'd1;
  endfunction

  function automatic logic [1:0] dec_mod3(input logic [1:0] a);
    return (a == 2'd0) ? 2'd2 : a - 2'd1;
  endfunction

  function automatic logic [2:0] dec_mod5(input logic [2:0] a);
    return (a == 3'd0) ? 3'd4 : a - 3'd1;
  endfunction

  // Rotations by a nonzero amount.
  function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] n);
    return (x << n) | (x >> (6'd0 - n));
  endfunction

  function automatic logic [63:0] rotr64(input logic [63:0] x, input logic [5:0] n);
    return (x >> n) | (x << (6'd0 - n));
  endfunction

endpackage

// ----- sv/tf256_key_sched.sv -----
// Threefish-256 key schedule: registers the four words of subkey s.
// Derives the parity key word and the third tweak word.
// Depends on tf256_pkg.
module tf256_key_sched (
  input  logic                 clk,
  input  logic [3:0][63:0]     key,
  input  logic [1:0][63:0]     tweak,
  input  tf256_pkg::ks_ctrl_t  ctrl,
  output logic [3:0][63:0]     sk
);
  import tf256_pkg::*;

  logic [4:0][63:0] k;
  logic [2:0][63:0] t;
  logic [1:0]       t_idx2;

  always_comb begin
    k[3:0] = key;
    k[4]   = key[0] ^ key[1] ^ key[2] ^ key[3] ^ TF_PARITY;
    t[1:0] = tweak;
    t[2]   = tweak[0] ^ tweak[1];
    t_idx2 = inc_mod3(ctrl.s3);
  end

  // Registered from the counter state ahead of its injection.
  always_ff @(posedge clk) begin
    sk[0] <= k[ctrl.s5];
    sk[1] <= k[add_mod5(ctrl.s5, 2'd1)] + t[ctrl.s3];
    sk[2] <= k[add_mod5(ctrl.s5, 2'd2)] + t[t_idx2];
    sk[3] <= k[add_mod5(ctrl.s5, 2'd3)] + {58'd0, ctrl.s};
  end

endmodule

// ----- sv/threefish_256_block_cipher.sv -----
// Threefish-256 block cipher, one round per cycle under a microcoded sequencer.
// The default of 9 round groups gives 72 rounds. A new block is taken only when the
// cipher is idle, once the previous block is done. One MIX/permute round or one
// subkey injection is done per step. The receiver cannot stall: done lasts one cycle.
// Synchronous reset clears the sequencer and the config registers (round_groups to 9).
module threefish_256_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        func,
  input  logic [63:0] in_word0,
  input  logic [63:0] in_word1,
  input  logic [63:0] in_word2,
  input  logic [63:0] in_word3,
  output logic        busy,
  output logic        done,
  output logic [63:0] out_word0,
  output logic [63:0] out_word1,
  output logic [63:0] out_word2,
  output logic [63:0] out_word3,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import tf256_pkg::*;

  logic [3:0][63:0] key_word;
  logic [1:0][63:0] tweak_word;
  logic [4:0]       round_groups;

  upc_t             upc, upc_next;
  uc_word_t         uc;
  logic [3:0][63:0] x, x_next;
  logic             func_q;
  ks_ctrl_t         ks, ks_next;
  logic [3:0][63:0] sk;

  logic [4:0]       groups;
  logic [5:0]       last;
  logic             accept;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;
  logic [2:0]       rot_idx;
  logic [5:0]       ra, rb;
  logic [63:0]      y0, y1, y2, y3;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[5:3]);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_word     <= '0;
      tweak_word   <= '0;
      round_groups <= DEFAULT_GROUPS;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KEY0:   key_word[0]   <= pwdata;
        REG_KEY1:   key_word[1]   <= pwdata;
        REG_KEY2:   key_word[2]   <= pwdata;
        REG_KEY3:   key_word[3]   <= pwdata;
        REG_TWEAK0: tweak_word[0] <= pwdata;
        REG_TWEAK1: tweak_word[1] <= pwdata;
        REG_ROUNDS: round_groups  <= pwdata[4:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_KEY0:   prdata = key_word[0];
      REG_KEY1:   prdata = key_word[1];
      REG_KEY2:   prdata = key_word[2];
      REG_KEY3:   prdata = key_word[3];
      REG_TWEAK0: prdata = tweak_word[0];
      REG_TWEAK1: prdata = tweak_word[1];
      REG_ROUNDS: prdata = {59'd0, round_groups};
      default:    prdata = '0;
    endcase
  end

  assign groups = (round_groups == 5'd0) ? DEFAULT_GROUPS : round_groups;
  assign last   = {groups, 1'b0};

  // Sequencer
  assign uc     = uc_rom(upc);
  assign busy   = (upc != UPC_IDLE);
  assign accept = start && !busy;
  assign done   = (uc.op == OP_DONE);

  always_comb begin
    case (uc.jc)
      JC_NONE:      upc_next = upc + 4'd1;
      JC_ALWAYS:    upc_next = uc.target;
      JC_NOT_START: upc_next = start ? upc + 4'd1 : uc.target;
      JC_FUNC:      upc_next = func_q ? uc.target : upc + 4'd1;
      JC_NOT_LAST:  upc_next = (ks.s != last) ? uc.target : upc + 4'd1;
      JC_ZERO:      upc_next = (ks.s == 6'd0) ? uc.target : upc + 4'd1;
      default:      upc_next = UPC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) upc <= UPC_IDLE;
    else     upc <= upc_next;
  end

  // Round datapath
  always_comb begin
    rot_idx = {(uc.op == OP_ENC) ? ~ks.s[0] : ks.s[0], uc.rnd};
    ra      = ROT_A[rot_idx];
    rb      = ROT_B[rot_idx];
    y0 = '0;
    y1 = '0;
    y2 = '0;
    y3 = '0;
    x_next  = x;
    ks_next = ks;
    case (uc.op)
      OP_IDLE: begin
        if (accept) begin
          x_next     = {in_word3, in_word2, in_word1, in_word0};
          ks_next.s  = func ? last : 6'd0;
          ks_next.s5 = func ? mod5_6b(last) : 3'd0;
          ks_next.s3 = func ? mod3_6b(last) : 2'd0;
        end
      end
      OP_INJ_ADD: begin
        for (int i = 0; i < 4; i++) x_next[i] = x[i] + sk[i];
        ks_next.s  = ks.s + 6'd1;
        ks_next.s5 = add_mod5(ks.s5, 2'd1);
        ks_next.s3 = inc_mod3(ks.s3);
      end
      OP_INJ_SUB: begin
        for (int i = 0; i < 4; i++) x_next[i] = x[i] - sk[i];
        ks_next.s  = ks.s - 6'd1;
        ks_next.s5 = dec_mod5(ks.s5);
        ks_next.s3 = dec_mod3(ks.s3);
      end
      OP_ENC: begin
        y0 = x[0] + x[1];
        y1 = rotl64(x[1], ra) ^ y0;
        y2 = x[2] + x[3];
        y3 = rotl64(x[3], rb) ^ y2;
        x_next = {y1, y2, y3, y0};
      end
      OP_DEC: begin
        // undo the word swap, then unmix both pairs
        y3 = rotr64(x[1] ^ x[2], rb);
        y2 = x[2] - y3;
        y1 = rotr64(x[3] ^ x[0], ra);
        y0 = x[0] - y1;
        x_next = {y3, y2, y1, y0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    x  <= x_next;
    ks <= ks_next;
    if (accept) func_q <= func;
  end

  tf256_key_sched u_key_sched (
    .clk   (clk),
    .key   (key_word),
    .tweak (tweak_word),
    .ctrl  (ks),
    .sk    (sk)
  );

  assign out_word0 = x[0];
  assign out_word1 = x[1];
  assign out_word2 = x[2];
  assign out_word3 = x[3];

endmodule

// ----- sv/tf256_checker.sv -----
// Port-level checks on the Threefish-256 command handshake and done strobe.
// Bound to threefish_256_block_cipher; no package dependency.
module tf256_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after a start transfer");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done strobe outside a busy period");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done |=> (!busy && !done))
    else $error("block still busy after its result");

  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result strobed right after the start transfer");

  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (!busy && !done))
    else $error("block not idle after reset");

endmodule

bind threefish_256_block_cipher tf256_checker u_tf256_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

// ----- sim/tb_top.sv -----
// Self-checking testbench for threefish_256_block_cipher: a directed table, then random
// phases of blocks under changing key, tweak and round settings, all checked per word.
// Depends on tf256_pkg (register indexes) and the cipher RTL.
`timescale 1ns / 1ps

module tb_top;
  import tf256_pkg::*;

  typedef logic [3:0][63:0] block_t;  // [i] is word i

  typedef struct packed {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [63:0] val;
    logic        dir;
    block_t      blk;
    bit          typed;
    block_t      want;
  } step_t;

  localparam logic [2:0]  REG_UNMAPPED = 3'd7;
  localparam logic [63:0] KEY_PARITY   = 64'h1BD11BDAA9FC1A22;
  localparam int          STD_GROUPS   = 9;
  localparam int          MAX_GROUPS   = 31;
  localparam logic        ENCRYPT      = 1'b0;
  localparam logic        DECRYPT      = 1'b1;
  localparam int          IDLE_LIMIT   = 4000;
  localparam int          TAIL_CYCLES  = 10 * MAX_GROUPS + 20;
  localparam int          NUM_PHASES   = 8;
  localparam int          PHASE_BLOCKS = 50;
  localparam logic [63:0] ONES         = {64{1'b1}};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        func = 1'b0;
  logic [63:0] in_word0 = '0, in_word1 = '0, in_word2 = '0, in_word3 = '0;
  logic        busy, done;
  logic [63:0] out_word0, out_word1, out_word2, out_word3;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  threefish_256_block_cipher dut (
    .clk(clk), .rst(rst), .start(start), .func(func),
    .in_word0(in_word0), .in_word1(in_word1), .in_word2(in_word2), .in_word3(in_word3),
    .busy(busy), .done(done),
    .out_word0(out_word0), .out_word1(out_word1), .out_word2(out_word2),
    .out_word3(out_word3),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the cipher's configuration.
  logic [63:0] key_sh [4];
  logic [63:0] tweak_sh [2];
  logic [4:0]  groups_sh;

  block_t cipher_out_q [$];
  int     err_count = 0;
  int     n_blocks = 0, n_decrypts = 0, n_results = 0, n_writes = 0;
  int     idle_cycles = 0;
  logic   last_dir;
  block_t last_out;

  function automatic int rot_amount(int d, bit second);
    case (d)
      0: return second ? 16 : 14;
      1: return second ? 57 : 52;
      2: return second ? 40 : 23;
      3: return second ? 37 : 5;
      4: return second ? 33 : 25;
      5: return second ? 12 : 46;
      6: return second ? 22 : 58;
      default: return 32;
    endcase
  endfunction

  function automatic logic [63:0] rotl(logic [63:0] x, int n);
    return (x << n) | (x >> (64 - n));
  endfunction

  function automatic logic [63:0] rotr(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] subkey_word(int s, int i);
    logic [63:0] k [5];
    logic [63:0] t [3];
    logic [63:0] v;
    for (int j = 0; j < 4; j++) k[j] = key_sh[j];
    k[4] = key_sh[0] ^ key_sh[1] ^ key_sh[2] ^ key_sh[3] ^ KEY_PARITY;
    t[0] = tweak_sh[0];
    t[1] = tweak_sh[1];
    t[2] = tweak_sh[0] ^ tweak_sh[1];
    v = k[(s + i) % 5];
    if (i == 1) v = v + t[s % 3];
    if (i == 2) v = v + t[(s + 1) % 3];
    if (i == 3) v = v + 64'(s);
    return v;
  endfunction

  function automatic block_t threefish_crypt(logic dir, block_t din);
    block_t      x;
    logic [63:0] tmp;
    int          last, base;
    x = din;
    last = 2 * ((groups_sh == 0) ? STD_GROUPS : int'(groups_sh));
    if (dir == ENCRYPT) begin
      for (int i = 0; i < 4; i++) x[i] = x[i] + subkey_word(0, i);
      for (int s = 1; s <= last; s++) begin
        base = ((s - 1) % 2) * 4;
        for (int d = 0; d < 4; d++) begin
          x[0] = x[0] + x[1];
          x[1] = rotl(x[1], rot_amount(base + d, 0)) ^ x[0];
          x[2] = x[2] + x[3];
          x[3] = rotl(x[3], rot_amount(base + d, 1)) ^ x[2];
          tmp = x[1]; x[1] = x[3]; x[3] = tmp;
        end
        for (int i = 0; i < 4; i++) x[i] = x[i] + subkey_word(s, i);
      end
    end else begin
      for (int s = last; s >= 1; s--) begin
        base = ((s - 1) % 2) * 4;
        for (int i = 0; i < 4; i++) x[i] = x[i] - subkey_word(s, i);
        for (int d = 3; d >= 0; d--) begin
          tmp = x[1]; x[1] = x[3]; x[3] = tmp;
          x[3] = rotr(x[3] ^ x[2], rot_amount(base + d, 1));
          x[2] = x[2] - x[3];
          x[1] = rotr(x[1] ^ x[0], rot_amount(base + d, 0));
          x[0] = x[0] - x[1];
        end
      end
      for (int i = 0; i < 4; i++) x[i] = x[i] - subkey_word(0, i);
    end
    return x;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ONES;
      2: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic step_t row_cfg(logic [2:0] idx, logic [63:0] val);
    step_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic step_t row_blk(logic dir, block_t blk, bit typed, block_t want);
    step_t r;
    r = '0;
    r.dir = dir;
    r.blk = blk;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // Write one register while the cipher is idle; mirror it in the shadow copy.
  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    while (cipher_out_q.size() != 0 || busy) @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 3'b000};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_sh[idx[1:0]] = val;
      REG_TWEAK0: tweak_sh[0] = val;
      REG_TWEAK1: tweak_sh[1] = val;
      REG_ROUNDS: groups_sh = val[4:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Hold start until the cipher takes the block, then queue its expected output.
  task automatic send_block(logic dir, block_t blk, bit typed, block_t want, int gap);
    block_t exp_out;
    exp_out = typed ? want : threefish_crypt(dir, blk);
    repeat (gap) @(negedge clk);
    start = 1'b1;
    func = dir;
    {in_word3, in_word2, in_word1, in_word0} = blk;
    do @(posedge clk); while (busy);
    cipher_out_q.push_back(exp_out);
    n_blocks++;
    if (dir == DECRYPT) n_decrypts++;
    last_dir = dir;
    last_out = exp_out;
    @(negedge clk);
    start = 1'b0;
  endtask

  // Result checker and watchdog.
  always @(posedge clk) begin
    block_t got, want;
    bit     moved;
    if (!rst) begin
      moved = (start && !busy) || done || (psel && penable && pwrite);
      if (done) begin
        got = {out_word3, out_word2, out_word1, out_word0};
        n_results++;
        if (cipher_out_q.size() == 0) begin
          if (err_count < 10) $display("unexpected result transfer: %h", got);
          err_count++;
        end else begin
          want = cipher_out_q.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (got[i] !== want[i]) begin
              if (err_count < 10)
                $display("out_word%0d mismatch on result %0d: expected %h, got %h",
                         i, n_results, want[i], got[i]);
              err_count++;
            end
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("** threefish_256_block_cipher: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    step_t  plan [$];
    step_t  r;
    block_t zero_blk, ones_blk, kat_ct, alt_blk, seq_blk, blk;
    logic   dir;
    bit     no_gaps;
    int     groups;

    for (int i = 0; i < 4; i++) key_sh[i] = '0;
    tweak_sh[0] = '0;
    tweak_sh[1] = '0;
    groups_sh = 5'(STD_GROUPS);
    last_dir = ENCRYPT;
    last_out = '0;

    zero_blk = '0;
    ones_blk = {4{ONES}};
    // Known answer for an all-zero key, tweak and block at 72 rounds.
    kat_ct = {64'hD83F13E63C9F6B11, 64'h952419A1F4B16D53,
              64'hADF103313EAE6670, 64'h94EEEA8B1F2ADA84};
    alt_blk = {64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555,
               64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555};
    seq_blk = {64'h1F1E1D1C1B1A1918, 64'h1716151413121110,
               64'h0F0E0D0C0B0A0908, 64'h0706050403020100};

    plan.push_back(row_blk(ENCRYPT, zero_blk, 1'b1, kat_ct));
    plan.push_back(row_blk(DECRYPT, kat_ct, 1'b1, zero_blk));
    plan.push_back(row_blk(ENCRYPT, ones_blk, 1'b0, '0));
    plan.push_back(row_blk(DECRYPT, ones_blk, 1'b0, '0));
    plan.push_back(row_cfg(REG_ROUNDS, 64'd1));
    plan.push_back(row_blk(ENCRYPT, alt_blk, 1'b0, '0));
    plan.push_back(row_blk(DECRYPT, alt_blk, 1'b0, '0));
    plan.push_back(row_cfg(REG_KEY0, ONES));
    plan.push_back(row_cfg(REG_KEY1, ONES));
    plan.push_back(row_cfg(REG_KEY2, ONES));
    plan.push_back(row_cfg(REG_KEY3, ONES));
    plan.push_back(row_cfg(REG_TWEAK0, ONES));
    plan.push_back(row_cfg(REG_TWEAK1, ONES));
    plan.push_back(row_blk(ENCRYPT, ones_blk, 1'b0, '0));
    plan.push_back(row_blk(DECRYPT, zero_blk, 1'b0, '0));
    plan.push_back(row_cfg(REG_ROUNDS, 64'(MAX_GROUPS)));
    plan.push_back(row_blk(ENCRYPT, seq_blk, 1'b0, '0));
    plan.push_back(row_blk(DECRYPT, seq_blk, 1'b0, '0));
    // zero groups falls back to the standard round count
    plan.push_back(row_cfg(REG_ROUNDS, 64'd0));
    plan.push_back(row_blk(ENCRYPT, zero_blk, 1'b0, '0));
    plan.push_back(row_blk(DECRYPT, ones_blk, 1'b0, '0));
    // only the low five bits of a round count write stick
    plan.push_back(row_cfg(REG_ROUNDS, 64'hFFFF_FFFF_FFFF_FFE2));
    plan.push_back(row_cfg(REG_UNMAPPED, ONES));
    plan.push_back(row_blk(ENCRYPT, alt_blk, 1'b0, '0));
    plan.push_back(row_blk(DECRYPT, seq_blk, 1'b0, '0));

    repeat (7) @(negedge clk);
    rst = 1'b0;

    foreach (plan[n]) begin
      r = plan[n];
      if (r.is_cfg) reg_write(r.idx, r.val);
      else send_block(r.dir, r.blk, r.typed, r.want, $urandom_range(0, 5));
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int k = REG_KEY0; k <= REG_TWEAK1; k++)
        if ($urandom_range(0, 2) != 0) reg_write(k[2:0], rand_word());
      case (p)
        0: groups = 1;
        1: groups = 2;
        2: groups = MAX_GROUPS;
        3: groups = 0;
        4: groups = $urandom_range(1, MAX_GROUPS);
        default: groups = $urandom_range(1, 5);
      endcase
      reg_write(REG_ROUNDS, {$urandom, $urandom} & ~64'h1F | 64'(groups));
      if ($urandom_range(0, 3) == 0) reg_write(REG_UNMAPPED, rand_word());
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int b = 0; b < PHASE_BLOCKS; b++) begin
        if ($urandom_range(0, 4) == 0 && b != 0) begin
          // undo the previous block
          dir = ~last_dir;
          blk = last_out;
        end else begin
          dir = 1'($urandom_range(0, 1));
          for (int i = 0; i < 4; i++) blk[i] = rand_word();
        end
        send_block(dir, blk, 1'b0, '0, no_gaps ? 0 : $urandom_range(0, 5));
      end
    end

    while (cipher_out_q.size() != 0 || busy) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (cipher_out_q.size() != 0) begin
      $display("%0d expected results never arrived", cipher_out_q.size());
      err_count++;
    end
    $display("ran %0d blocks (%0d decryptions), %0d results, %0d register writes",
             n_blocks, n_decrypts, n_results, n_writes);
    $display("round settings swept from 1 to %0d groups, zero and wide writes included",
             MAX_GROUPS);
    if (err_count == 0) begin
      $display("** threefish_256_block_cipher: PASSED **");
    end else begin
      $display("%0d mismatches", err_count);
      $display("** threefish_256_block_cipher: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/tf256_pkg.sv
sv/tf256_key_sched.sv
sv/threefish_256_block_cipher.sv
sv/tf256_checker.sv
sim/tb_top.sv
